### rtl/lbb_pkg.sv
package lbb_pkg;

  // field and state widths
  localparam int CH_W   = 3;
  localparam int OP_W   = 2;
  localparam int CNT_W  = 11;
  localparam int RAMP_W = 6;
  localparam int MODE_W = 4;
  localparam int MAX_CH = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;

  // item opcodes, the unused code behaves as a plain tick
  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_ON   = 2'd1,
    OP_OFF  = 2'd2
  } op_t;

  // what one channel lane reports for the item that addresses it
  typedef struct packed {
    logic pin;
    logic sw_on;
  } lane_res_t;

  // mode codes beyond the table fall back to mode 0
  function automatic logic [MODE_W-1:0] mode_decode(input logic [MODE_W-1:0] m);
    logic [MODE_W-1:0] r;
    r = (m > 4'd8) ? 4'd0 : m;
    return r;
  endfunction

  // on-count of each blink mode
  function automatic logic [CNT_W-1:0] mode_on_cnt(input logic [MODE_W-1:0] m);
    logic [CNT_W-1:0] r;
    case (m)
      4'd1:    r = 11'd6;
      4'd2:    r = 11'd3;
      4'd3:    r = 11'd1;
      4'd4:    r = 11'd1;
      4'd5:    r = 11'd200;
      4'd6:    r = 11'd750;
      4'd7:    r = 11'd100;
      4'd8:    r = 11'd1;
      default: r = 11'd10;
    endcase
    return r;
  endfunction

  // off-count of each blink mode
  function automatic logic [CNT_W-1:0] mode_off_cnt(input logic [MODE_W-1:0] m);
    logic [CNT_W-1:0] r;
    case (m)
      4'd1:    r = 11'd4;
      4'd2:    r = 11'd7;
      4'd3:    r = 11'd9;
      4'd4:    r = 11'd19;
      4'd5:    r = 11'd200;
      4'd6:    r = 11'd750;
      4'd7:    r = 11'd1400;
      4'd8:    r = 11'd19;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/lbb_lane.sv
module lbb_lane #(
  parameter int RAMP_INTERVAL = 40,
  parameter int BREATHE_MODE  = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick,
  input  lbb_pkg::op_t                opcode,
  input  logic [lbb_pkg::MODE_W-1:0]  mode,
  input  logic                        reload,
  input  logic [lbb_pkg::MODE_W-1:0]  reload_mode,
  output lbb_pkg::lane_res_t          res
);
  import lbb_pkg::*;

  localparam logic [RAMP_W:0]  RAMP_LIMIT = (RAMP_W+1)'(RAMP_INTERVAL);
  localparam logic [MODE_W-1:0] BREATHE   = MODE_W'(BREATHE_MODE);

  logic              sw_r, sw_nxt;
  logic [CNT_W-1:0]  phase_r, phase_nxt, phase_cur;
  logic [CNT_W-1:0]  on_r, on_nxt;
  logic [CNT_W-1:0]  off_r, off_nxt;
  logic [RAMP_W-1:0] ramp_r, ramp_nxt;
  logic              down_r, down_nxt;
  logic [CNT_W:0]    phase_inc;
  logic [CNT_W:0]    sum;
  logic [RAMP_W:0]   rc;
  logic [MODE_W-1:0] reload_dec;

  assign reload_dec = mode_decode(reload_mode);

  // opcode, pin level and phase advance
  always_comb begin
    sw_nxt    = sw_r;
    phase_cur = phase_r;
    case (opcode)
      OP_ON: begin
        phase_cur = '0;
        sw_nxt    = 1'b1;
      end
      OP_OFF: begin
        sw_nxt = 1'b0;
      end
      default: ;
    endcase
    res.pin   = sw_nxt && (phase_cur < on_r);
    res.sw_on = sw_nxt;
    phase_inc = {1'b0, phase_cur} + {{CNT_W{1'b0}}, 1'b1};
    sum       = {1'b0, on_r} + {1'b0, off_r};
    phase_nxt = (phase_inc >= sum) ? '0 : phase_inc[CNT_W-1:0];
  end

  // breathing ramp: shift the on/off split, reverse at either end
  always_comb begin
    on_nxt   = on_r;
    off_nxt  = off_r;
    ramp_nxt = ramp_r;
    down_nxt = down_r;
    rc       = {1'b0, ramp_r} + {{RAMP_W{1'b0}}, 1'b1};
    if (mode_decode(mode) == BREATHE) begin
      if (rc > RAMP_LIMIT) begin
        rc = '0;
        if (!down_r) begin
          if (off_r == '0) begin
            on_nxt   = sum[CNT_W-1:0];
            down_nxt = 1'b1;
          end else begin
            on_nxt  = on_r + 11'd1;
            off_nxt = off_r - 11'd1;
          end
        end else begin
          if (on_r == '0) begin
            off_nxt  = sum[CNT_W-1:0];
            down_nxt = 1'b0;
          end else begin
            on_nxt  = on_r - 11'd1;
            off_nxt = off_r + 11'd1;
          end
        end
      end
      ramp_nxt = rc[RAMP_W-1:0];
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r    <= 1'b0;
      phase_r <= '0;
      on_r    <= mode_on_cnt(4'd0);
      off_r   <= mode_off_cnt(4'd0);
      ramp_r  <= '0;
      down_r  <= 1'b0;
    end else if (reload) begin
      on_r  <= mode_on_cnt(reload_dec);
      off_r <= mode_off_cnt(reload_dec);
    end else if (tick) begin
      sw_r    <= sw_nxt;
      phase_r <= phase_nxt;
      on_r    <= on_nxt;
      off_r   <= off_nxt;
      ramp_r  <= ramp_nxt;
      down_r  <= down_nxt;
    end
  end

endmodule

### rtl/led_blink_breathe_controller_core.sv
// each input transfer's result is registered and appears on the out channel next cycle
// throughput: one item per cycle unless the out channel stalls; each item updates at most
// one lane in one pass of compare, increment and clamp logic before the result register
// reset: synchronous, active low; all channels off, phase and ramp zero,
// counts of mode 0, mode and enable registers zero
module led_blink_breathe_controller_core #(
  parameter int CHANNELS      = 8,
  parameter int RAMP_INTERVAL = 40,
  parameter int BREATHE_MODE  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // opcode[1:0], channel[4:2], zero pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata   // channel_out[2:0], pin_level[3],
                                                     // logical_on[4], accepted[5], zero pad
);
  import lbb_pkg::*;

  localparam logic [CH_W:0] CH_LIMIT = (CH_W+1)'(CHANNELS);

  logic [31:0]        modes_r;
  logic [MAX_CH-1:0]  enable_r;
  logic               accept;
  logic               enabled;
  op_t                opcode;
  logic [CH_W-1:0]    chan;
  logic               reload;
  lane_res_t          lane_res [CHANNELS];
  lane_res_t          sel_res;

  logic               out_valid_r;
  logic [CH_W-1:0]    out_chan_r;
  logic               out_pin_r;
  logic               out_on_r;
  logic               out_acc_r;

  assign opcode  = op_t'(in_tdata[1:0]);
  assign chan    = in_tdata[4:2];
  assign in_tready = !out_valid_r || out_tready;
  assign accept  = in_tvalid && in_tready;
  assign enabled = ({1'b0, chan} < CH_LIMIT) && enable_r[chan];
  assign reload  = cfg_we && (cfg_index == CFG_MODES);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modes_r  <= '0;
      enable_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODES:  modes_r  <= cfg_wdata;
        CFG_ENABLE: enable_r <= cfg_wdata[MAX_CH-1:0];
        default: ;
      endcase
    end
  end

  // one lane per channel
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    lbb_lane #(
      .RAMP_INTERVAL (RAMP_INTERVAL),
      .BREATHE_MODE  (BREATHE_MODE)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .tick        (accept && enabled && (chan == CH_W'(g))),
      .opcode      (opcode),
      .mode        (modes_r[g*MODE_W +: MODE_W]),
      .reload      (reload),
      .reload_mode (cfg_wdata[g*MODE_W +: MODE_W]),
      .res         (lane_res[g])
    );
  end

  // pick the addressed lane's result
  always_comb begin
    sel_res = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (chan == CH_W'(i)) begin
        sel_res = lane_res[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_chan_r <= chan;
      out_pin_r  <= enabled && sel_res.pin;
      out_on_r   <= enabled && sel_res.sw_on;
      out_acc_r  <= enabled;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_acc_r, out_on_r, out_pin_r, out_chan_r};

endmodule

### rtl/lbb_checker.sv
module lbb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every input transfer shows its result in the next cycle for the same channel
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid && (out_tdata[2:0] == $past(in_tdata[4:2])))
    else $error("result missing or for the wrong channel");

  // an empty output stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a rejected item reports pin low and channel off
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[5] |-> !out_tdata[3] && !out_tdata[4])
    else $error("rejected item with live fields");

  // the pin is only driven while the channel is switched on
  a_pin_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[4])
    else $error("pin high on a switched-off channel");

endmodule

bind led_blink_breathe_controller_core lbb_checker u_lbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
